FILE: sv/mhdk_pkg.sv
// Shared widths, request/status codes and key arithmetic for the min-heap block.
package mhdk_pkg;

    localparam int KEY_W    = 64;
    localparam int HND_W    = 12;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET_MIN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EXTRACT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DECREASE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_STALE = 2'd3;

    localparam logic signed [KEY_W-1:0] EMPTY_SENTINEL = 64'sd100000000000000000;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    // a - d, clamped to the signed range
    function automatic logic signed [KEY_W-1:0] sat_sub(
        input logic signed [KEY_W-1:0] a,
        input logic signed [KEY_W-1:0] d
    );
        logic signed [KEY_W-1:0] r;
        r = a - d;
        if ((a[KEY_W-1] != d[KEY_W-1]) && (a[KEY_W-1] != r[KEY_W-1])) begin
            r = a[KEY_W-1] ? KEY_MIN : KEY_MAX;
        end
        return r;
    endfunction

endpackage

FILE: sv/min_heap_with_decrease_key.sv
// Binary min-heap with handles and decrease-key, held in two synchronous memories.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_req_type s_key_value  | in
//          | s_handle                                |
//  m_      | m_valid m_ready m_min_key m_status      | out
//
// One word at a time. Insert, extract and decrease-key walk the heap level by
// level, each level being one slot memory read and then one compare and write.
// After reset a clearing pass zeroes every entry of the handle table; s_ready
// stays low meanwhile. A stalled result holds the block in its response state
// until m_ready.
module min_heap_with_decrease_key import mhdk_pkg::*; #(
    parameter int HEAP_DEPTH   = 1024,
    parameter int HANDLE_COUNT = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [REQ_W-1:0]           s_req_type,
    input  logic signed [KEY_W-1:0]    s_key_value,
    input  logic [HND_W-1:0]           s_handle,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [KEY_W-1:0]    m_min_key,
    output logic [STATUS_W-1:0]        m_status
);

    localparam int SW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int OPW = $clog2(HANDLE_COUNT);
    localparam int LW  = SW + 2;
    localparam int EW  = KEY_W + OPW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_GMIN, ST_EXLOAD, ST_DKLOOK, ST_DKLOAD,
        ST_UP, ST_UPCMP, ST_DOWN, ST_DNCMP, ST_FIN, ST_RESP
    } state_t;

    state_t                  state_reg;
    logic [OPW-1:0]          clr_reg;
    logic [CW-1:0]           count_reg;
    logic [OPW-1:0]          op_reg;
    logic [SW-1:0]           pos_reg;
    logic signed [KEY_W-1:0] mkey_reg;
    logic [OPW-1:0]          mhnd_reg;
    logic signed [KEY_W-1:0] delta_reg;
    logic [STATUS_W-1:0]     stat_reg;
    logic signed [KEY_W-1:0] rkey_reg;
    logic [SW-1:0]           lidx_reg;
    logic [SW-1:0]           ridx_reg;
    logic                    rok_reg;
    logic                    m_valid_reg;
    logic signed [KEY_W-1:0] m_min_key_reg;
    logic [STATUS_W-1:0]     m_status_reg;

    // slot memory: {handle, key}; handle table: {valid, slot}
    logic [EW-1:0] slot_mem [HEAP_DEPTH];
    logic [SW:0]   hnd_mem  [HANDLE_COUNT];
    logic [EW-1:0] rda_reg, rdb_reg;
    logic [SW:0]   hrd_reg;

    logic [SW-1:0]  ra_addr, rb_addr, sw_addr;
    logic [OPW-1:0] ha_addr, hw_addr;
    logic           sw_en, hw_en;
    logic [EW-1:0]  sw_data;
    logic [SW:0]    hw_data;

    logic [OPW:0]            op_inc;
    logic                    op_sat;
    logic [OPW-1:0]          next_op;
    logic                    full, empty;
    logic [CW-1:0]           last;
    logic [SW-1:0]           parent;
    logic [LW-1:0]           lft, rgt;
    logic                    left_ok, right_ok;
    logic signed [KEY_W-1:0] a_key, b_key;
    logic [OPW-1:0]          a_hnd;
    logic [SW-1:0]           hrd_pos;
    logic signed [KEY_W-1:0] best_key;
    logic [EW-1:0]           best_ent;
    logic [SW-1:0]           best_idx;
    logic                    best_swap;

    assign op_inc  = (OPW+1)'(op_reg) + (OPW+1)'(1);
    assign op_sat  = op_inc >= (OPW+1)'(HANDLE_COUNT);
    assign next_op = op_sat ? op_reg : op_inc[OPW-1:0];
    assign full    = count_reg == CW'(HEAP_DEPTH);
    assign empty   = count_reg == '0;
    assign last    = count_reg - CW'(1);
    assign parent  = SW'((pos_reg - SW'(1)) >> 1);
    assign lft     = LW'({pos_reg, 1'b1});
    assign rgt     = lft + LW'(1);
    assign left_ok  = lft < LW'(count_reg);
    assign right_ok = rgt < LW'(count_reg);
    assign a_key   = $signed(rda_reg[KEY_W-1:0]);
    assign b_key   = $signed(rdb_reg[KEY_W-1:0]);
    assign a_hnd   = rda_reg[EW-1:KEY_W];
    assign hrd_pos = hrd_reg[SW-1:0];

    // smallest of the hole's entry and its children
    always_comb begin
        best_key  = mkey_reg;
        best_ent  = rda_reg;
        best_idx  = lidx_reg;
        best_swap = 1'b0;
        if (a_key < best_key) begin
            best_key  = a_key;
            best_swap = 1'b1;
        end
        if (rok_reg && (b_key < best_key)) begin
            best_key  = b_key;
            best_ent  = rdb_reg;
            best_idx  = ridx_reg;
            best_swap = 1'b1;
        end
    end

    always_comb begin
        ra_addr = '0;
        rb_addr = '0;
        ha_addr = OPW'(s_handle);
        case (state_reg)
            ST_IDLE:   rb_addr = last[SW-1:0];
            ST_UP:     ra_addr = parent;
            ST_DOWN: begin
                ra_addr = lft[SW-1:0];
                rb_addr = rgt[SW-1:0];
            end
            ST_DKLOOK: ra_addr = hrd_pos;
            default:   ra_addr = '0;
        endcase
    end

    always_comb begin
        sw_en   = 1'b0;
        sw_addr = pos_reg;
        sw_data = {mhnd_reg, mkey_reg};
        hw_en   = 1'b0;
        hw_addr = mhnd_reg;
        hw_data = {1'b1, pos_reg};
        case (state_reg)
            ST_CLEAR: begin
                hw_en   = 1'b1;
                hw_addr = clr_reg;
                hw_data = '0;
            end
            ST_EXLOAD: begin
                hw_en   = 1'b1;
                hw_addr = a_hnd;
                hw_data = '0;
            end
            ST_UPCMP: begin
                if (mkey_reg < a_key) begin
                    sw_en   = 1'b1;
                    sw_data = rda_reg;
                    hw_en   = 1'b1;
                    hw_addr = a_hnd;
                end
            end
            ST_DNCMP: begin
                if (best_swap) begin
                    sw_en   = 1'b1;
                    sw_data = best_ent;
                    hw_en   = 1'b1;
                    hw_addr = best_ent[EW-1:KEY_W];
                end
            end
            ST_FIN: begin
                sw_en = 1'b1;
                hw_en = 1'b1;
            end
            default: sw_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sw_en) begin
            slot_mem[sw_addr] <= sw_data;
        end
        rda_reg <= slot_mem[ra_addr];
        rdb_reg <= slot_mem[rb_addr];
    end

    always_ff @(posedge aclk) begin
        if (hw_en) begin
            hnd_mem[hw_addr] <= hw_data;
        end
        hrd_reg <= hnd_mem[ha_addr];
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_min_key = m_min_key_reg;
    assign m_status  = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            op_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the response state reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + OPW'(1);
                    if (clr_reg == OPW'(HANDLE_COUNT - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= next_op;
                        delta_reg <= s_key_value;
                        case (s_req_type)
                            REQ_INSERT: begin
                                rkey_reg <= '0;
                                if (op_sat || full) begin
                                    stat_reg  <= STAT_FULL;
                                    state_reg <= ST_RESP;
                                end else begin
                                    stat_reg  <= STAT_OK;
                                    mkey_reg  <= s_key_value;
                                    mhnd_reg  <= op_inc[OPW-1:0];
                                    pos_reg   <= count_reg[SW-1:0];
                                    count_reg <= count_reg + CW'(1);
                                    state_reg <= ST_UP;
                                end
                            end
                            REQ_GET_MIN: begin
                                if (empty) begin
                                    rkey_reg  <= EMPTY_SENTINEL;
                                    stat_reg  <= STAT_EMPTY;
                                    state_reg <= ST_RESP;
                                end else begin
                                    stat_reg  <= STAT_OK;
                                    state_reg <= ST_GMIN;
                                end
                            end
                            REQ_EXTRACT: begin
                                rkey_reg <= '0;
                                if (empty) begin
                                    stat_reg  <= STAT_EMPTY;
                                    state_reg <= ST_RESP;
                                end else begin
                                    stat_reg  <= STAT_OK;
                                    count_reg <= last;
                                    state_reg <= ST_EXLOAD;
                                end
                            end
                            default: begin
                                rkey_reg <= '0;
                                if (32'(s_handle) >= HANDLE_COUNT) begin
                                    stat_reg  <= STAT_STALE;
                                    state_reg <= ST_RESP;
                                end else begin
                                    stat_reg  <= STAT_OK;
                                    state_reg <= ST_DKLOOK;
                                end
                            end
                        endcase
                    end
                end
                ST_GMIN: begin
                    rkey_reg  <= a_key;
                    state_reg <= ST_RESP;
                end
                ST_EXLOAD: begin
                    // last entry moves into the root hole
                    mkey_reg <= b_key;
                    mhnd_reg <= rdb_reg[EW-1:KEY_W];
                    pos_reg  <= '0;
                    state_reg <= empty ? ST_RESP : ST_DOWN;
                end
                ST_DKLOOK: begin
                    if (!hrd_reg[SW] || (CW'(hrd_pos) >= count_reg)) begin
                        stat_reg  <= STAT_STALE;
                        state_reg <= ST_RESP;
                    end else begin
                        pos_reg   <= hrd_pos;
                        state_reg <= ST_DKLOAD;
                    end
                end
                ST_DKLOAD: begin
                    mkey_reg <= sat_sub(a_key, delta_reg);
                    mhnd_reg <= a_hnd;
                    if (!delta_reg[KEY_W-1] && (delta_reg != '0) && (pos_reg != '0)) begin
                        state_reg <= ST_UP;
                    end else begin
                        state_reg <= ST_DOWN;
                    end
                end
                ST_UP: begin
                    state_reg <= (pos_reg == '0) ? ST_FIN : ST_UPCMP;
                end
                ST_UPCMP: begin
                    if (mkey_reg < a_key) begin
                        pos_reg   <= parent;
                        state_reg <= ST_UP;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_DOWN: begin
                    if (!left_ok) begin
                        state_reg <= ST_FIN;
                    end else begin
                        lidx_reg  <= lft[SW-1:0];
                        ridx_reg  <= rgt[SW-1:0];
                        rok_reg   <= right_ok;
                        state_reg <= ST_DNCMP;
                    end
                end
                ST_DNCMP: begin
                    if (best_swap) begin
                        pos_reg   <= best_idx;
                        state_reg <= ST_DOWN;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_min_key_reg <= rkey_reg;
                        m_status_reg  <= stat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the min-heap block with handles and decrease-key.
module tb_top import mhdk_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH   = 1024;
    localparam int HANDLE_COUNT = 4096;
    localparam int N_RANDOM     = 200;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_CYCLES  = 400;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type;
    logic signed [KEY_W-1:0] s_key_value;
    logic [HND_W-1:0]        s_handle;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [KEY_W-1:0] m_min_key;
    logic [STATUS_W-1:0]     m_status;

    min_heap_with_decrease_key #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .HANDLE_COUNT(HANDLE_COUNT)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_key_value(s_key_value),
        .s_handle   (s_handle),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_min_key  (m_min_key),
        .m_status   (m_status)
    );

    typedef struct {
        logic signed [KEY_W-1:0] min_key;
        logic [STATUS_W-1:0]     status;
    } answer_t;

    // heap mirror
    logic signed [KEY_W-1:0] heap_key [HEAP_DEPTH];
    int                      heap_id  [HEAP_DEPTH];
    int                      id_slot  [HANDLE_COUNT];
    bit                      id_live  [HANDLE_COUNT];
    int                      entries;
    int                      op_num;
    int                      issued_ids[$];

    answer_t pending_answers[$];
    int      errors;
    int      cycles = 0;
    int      req_seen[4];
    int      status_seen[4];
    bit      quiet;
    bit      hold_req;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit key_lt(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
        return a < b;
    endfunction

    function automatic void swap_entries(int a, int b);
        logic signed [KEY_W-1:0] k;
        int h;
        k = heap_key[a];
        h = heap_id[a];
        heap_key[a] = heap_key[b];
        heap_id[a]  = heap_id[b];
        heap_key[b] = k;
        heap_id[b]  = h;
        id_slot[heap_id[a]] = a;
        id_slot[heap_id[b]] = b;
    endfunction

    function automatic void sift_up(int pos);
        int parent;
        while (pos != 0) begin
            parent = (pos - 1) / 2;
            if (!key_lt(heap_key[pos], heap_key[parent])) break;
            swap_entries(pos, parent);
            pos = parent;
        end
    endfunction

    function automatic void sink_entry(int pos);
        int best;
        int left;
        forever begin
            best = pos;
            left = 2 * pos + 1;
            if (left < entries && key_lt(heap_key[left], heap_key[best])) best = left;
            if (left + 1 < entries && key_lt(heap_key[left+1], heap_key[best])) best = left + 1;
            if (best == pos) break;
            swap_entries(pos, best);
            pos = best;
        end
    endfunction

    function automatic logic signed [KEY_W-1:0] clamp_sub(logic signed [KEY_W-1:0] a,
                                                          logic signed [KEY_W-1:0] d);
        logic signed [KEY_W:0] wide;
        wide = {a[KEY_W-1], a} - {d[KEY_W-1], d};
        if (wide > $signed({KEY_MAX[KEY_W-1], KEY_MAX})) return KEY_MAX;
        if (wide < $signed({KEY_MIN[KEY_W-1], KEY_MIN})) return KEY_MIN;
        return wide[KEY_W-1:0];
    endfunction

    // advances the mirror by one word and returns its answer
    function automatic answer_t heap_apply(logic [REQ_W-1:0] req, logic signed [KEY_W-1:0] val,
                                           logic [HND_W-1:0] hnd);
        answer_t ans;
        int nxt;
        int pos;
        ans.min_key = '0;
        ans.status  = STAT_OK;
        nxt = (op_num + 1 < HANDLE_COUNT) ? op_num + 1 : op_num;
        case (req)
            REQ_INSERT: begin
                if (op_num + 1 >= HANDLE_COUNT || entries >= HEAP_DEPTH) begin
                    ans.status = STAT_FULL;
                end else begin
                    heap_key[entries] = val;
                    heap_id[entries]  = nxt;
                    id_slot[nxt] = entries;
                    id_live[nxt] = 1'b1;
                    issued_ids.push_back(nxt);
                    entries++;
                    sift_up(entries - 1);
                end
            end
            REQ_GET_MIN: begin
                if (entries == 0) begin
                    ans.min_key = EMPTY_SENTINEL;
                    ans.status  = STAT_EMPTY;
                end else begin
                    ans.min_key = heap_key[0];
                end
            end
            REQ_EXTRACT: begin
                if (entries == 0) begin
                    ans.status = STAT_EMPTY;
                end else begin
                    id_live[heap_id[0]] = 1'b0;
                    if (entries > 1) begin
                        heap_key[0] = heap_key[entries-1];
                        heap_id[0]  = heap_id[entries-1];
                        id_slot[heap_id[0]] = 0;
                    end
                    entries--;
                    sink_entry(0);
                end
            end
            default: begin
                if (!id_live[hnd] || id_slot[hnd] >= entries) begin
                    ans.status = STAT_STALE;
                end else begin
                    pos = id_slot[hnd];
                    heap_key[pos] = clamp_sub(heap_key[pos], val);
                    if (val > 0 && pos != 0) sift_up(pos);
                    else sink_entry(pos);
                end
            end
        endcase
        op_num = nxt;
        return ans;
    endfunction

    task automatic send_word(logic [REQ_W-1:0] req, logic signed [KEY_W-1:0] val,
                             logic [HND_W-1:0] hnd, bit typed, answer_t typed_ans);
        answer_t ans;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_key_value <= val;
        s_handle    <= hnd;
        do @(posedge aclk); while (!s_ready);
        ans = heap_apply(req, val, hnd);
        pending_answers.push_back(typed ? typed_ans : ans);
        req_seen[req]++;
    endtask

    task automatic drain_answers();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_answers.size() == 0);
    endtask

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 7))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2, 3: return {$urandom, $urandom};
            default: return $signed(64'($urandom_range(0, 2000))) - 1000;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_delta();
        case ($urandom_range(0, 9))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            3: return -$signed(64'($urandom_range(1, 500)));
            4: return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 800));
        endcase
    endfunction

    function automatic logic [HND_W-1:0] rand_handle();
        if (issued_ids.size() == 0 || $urandom_range(0, 5) == 0)
            return HND_W'($urandom_range(0, HANDLE_COUNT - 1));
        return HND_W'(issued_ids[$urandom_range(0, issued_ids.size() - 1)]);
    endfunction

    task automatic send_random(int w_ins, int w_get, int w_ext);
        int pick;
        logic [REQ_W-1:0] req;
        answer_t none;
        none = '{'0, STAT_OK};
        pick = $urandom_range(0, 99);
        if (pick < w_ins) req = REQ_INSERT;
        else if (pick < w_ins + w_get) req = REQ_GET_MIN;
        else if (pick < w_ins + w_get + w_ext) req = REQ_EXTRACT;
        else req = REQ_DECREASE;
        send_word(req, req == REQ_DECREASE ? rand_delta() : rand_key(),
                  rand_handle(), 1'b0, none);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int burst;
        m_ready = 1'b0;
        burst = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_ready <= (burst == 0);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result word with nothing expected: min_key %0d status %0d",
                       m_min_key, m_status);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                status_seen[m_status]++;
                if (m_min_key !== want.min_key) begin
                    $error("min_key: expected %0d, got %0d", want.min_key, m_min_key);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        logic [REQ_W-1:0]        req;
        logic signed [KEY_W-1:0] val;
        logic [HND_W-1:0]        hnd;
        bit                      typed;
        answer_t                 ans;
    } stim_row_t;

    // insert numbers: ops 4,5,6 are inserts, op 15 is an insert
    stim_row_t directed[] = '{
        '{REQ_GET_MIN,  '0,      12'd0,    1, '{EMPTY_SENTINEL, STAT_EMPTY}},
        '{REQ_EXTRACT,  '0,      12'd0,    1, '{'0, STAT_EMPTY}},
        '{REQ_DECREASE, 64'sd5,  12'd1,    1, '{'0, STAT_STALE}},
        '{REQ_INSERT,   KEY_MAX, 12'd0,    0, '{'0, STAT_OK}},
        '{REQ_INSERT,   KEY_MIN, 12'd0,    0, '{'0, STAT_OK}},
        '{REQ_INSERT,   '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_GET_MIN,  '0,      12'd0,    1, '{KEY_MIN, STAT_OK}},
        '{REQ_DECREASE, KEY_MIN, 12'd4,    0, '{'0, STAT_OK}},
        '{REQ_DECREASE, 64'sd1,  12'd6,    0, '{'0, STAT_OK}},
        '{REQ_DECREASE, 64'sd1,  12'd5,    0, '{'0, STAT_OK}},
        '{REQ_DECREASE, 64'sd1,  12'hfff,  1, '{'0, STAT_STALE}},
        '{REQ_EXTRACT,  '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_DECREASE, 64'sd1,  12'd5,    1, '{'0, STAT_STALE}},
        '{REQ_GET_MIN,  '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_INSERT,   -64'sd5, 12'd0,    0, '{'0, STAT_OK}},
        '{REQ_DECREASE, '0,      12'd15,   0, '{'0, STAT_OK}},
        '{REQ_DECREASE, -64'sd100, 12'd6,  0, '{'0, STAT_OK}},
        '{REQ_DECREASE, KEY_MAX, 12'd4,    0, '{'0, STAT_OK}},
        '{REQ_GET_MIN,  '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_EXTRACT,  '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_EXTRACT,  '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_EXTRACT,  '0,      12'd0,    0, '{'0, STAT_OK}},
        '{REQ_EXTRACT,  '0,      12'd0,    1, '{'0, STAT_EMPTY}},
        '{REQ_DECREASE, 64'sd1,  12'd15,   1, '{'0, STAT_STALE}}
    };

    initial begin
        answer_t none;
        int wait_cycles;
        none = '{'0, STAT_OK};
        errors = 0;
        entries = 0;
        op_num = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        foreach (id_live[i]) id_live[i] = 1'b0;
        foreach (req_seen[i]) req_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_GET_MIN;
        s_key_value = '0;
        s_handle = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].req, directed[i].val, directed[i].hnd,
                      directed[i].typed, directed[i].ans);
        drain_answers();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) hold_req = 1'b1;
            send_random(45, 15, 20);
        end
        // sender waits until every expected result has arrived
        drain_answers();

        // fill to capacity, then a few rejected inserts
        while (entries < HEAP_DEPTH) send_random(100, 0, 0);
        repeat (4) send_random(100, 0, 0);

        // no idling near the end
        quiet = 1'b1;
        repeat (40) send_random(20, 30, 30);
        @(negedge aclk);
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_answers.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (50) @(posedge aclk);
        if (pending_answers.size() != 0) begin
            $error("%0d expected results never arrived", pending_answers.size());
            errors++;
        end

        $display("words: %0d insert, %0d get-min, %0d extract, %0d decrease-key",
                 req_seen[0], req_seen[1], req_seen[2], req_seen[3]);
        $display("statuses: %0d ok, %0d empty, %0d full, %0d stale; heap held %0d at end",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], entries);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mhdk_pkg.sv
sv/min_heap_with_decrease_key.sv
tb/tb_top.sv
